// File: hw/rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and codes for the sorted table binary search
// Holds the input and result word layouts, the operation codes and the
// search engine state type.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Operation codes carried in the op field of an input word.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Width of the reported position field.
  localparam int POS_WIDTH = 10;

  // One input word.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic                 found;
    logic [POS_WIDTH-1:0] position;
  } out_word_t;

  // Search engine states.
  typedef enum logic {
    SE_IDLE,
    SE_RUN
  } se_state_t;

endpackage

// File: hw/rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/stbs_search.sv
// ----------------------------------------------------------------------------
// stbs_search: binary search engine over the key memory
// Probes one table entry per cycle, narrowing the range [base, base+len)
// until a match is seen or the range is empty, then posts one result word.
// ----------------------------------------------------------------------------
module stbs_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [CW-1:0]        count_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [KEY_WIDTH-1:0] rd_data_i,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output out_word_t            res_o
);

  se_state_t            state_r, state_nxt;
  logic [CW-1:0]        base_r, base_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 res_valid_r, res_valid_nxt;
  out_word_t            res_r, res_nxt;

  logic [CW-1:0] half;
  logic [CW-1:0] base_step;
  logic [CW-1:0] len_step;
  logic          hit;
  logic          above;

  // Compare the probed entry with the key and form the narrowed range.
  always_comb begin
    half      = len_r >> 1;
    hit       = $signed(rd_data_i) == $signed(key_r);
    above     = $signed(rd_data_i) > $signed(key_r);
    base_step = above ? base_r : CW'(mid_r) + CW'(1);
    len_step  = above ? half : len_r - half - CW'(1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SE_IDLE: begin
        if (start_i && (count_i != '0)) begin
          state_nxt = SE_RUN;
        end
      end
      SE_RUN: begin
        if (hit || (len_step == '0)) begin
          state_nxt = SE_IDLE;
        end
      end
      default: state_nxt = SE_IDLE;
    endcase
  end

  // Datapath, memory read and result.
  always_comb begin
    base_nxt      = base_r;
    len_nxt       = len_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    rd_en_o       = 1'b0;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    unique case (state_r)
      SE_IDLE: begin
        if (start_i) begin
          key_nxt = key_i;
          if (count_i == '0) begin
            // Empty table answers not found at once.
            res_valid_nxt    = 1'b1;
            res_nxt.found    = 1'b0;
            res_nxt.position = '0;
          end else begin
            base_nxt = '0;
            len_nxt  = count_i;
            mid_nxt  = AW'(count_i >> 1);
            rd_en_o  = 1'b1;
          end
        end
      end
      SE_RUN: begin
        if (hit) begin
          res_valid_nxt    = 1'b1;
          res_nxt.found    = 1'b1;
          res_nxt.position = POS_WIDTH'(mid_r);
        end else if (len_step == '0) begin
          res_valid_nxt    = 1'b1;
          res_nxt.found    = 1'b0;
          res_nxt.position = '0;
        end else begin
          base_nxt = base_step;
          len_nxt  = len_step;
          mid_nxt  = AW'(base_step + (len_step >> 1));
          rd_en_o  = 1'b1;
        end
      end
      default: begin
        res_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SE_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    len_r  <= len_nxt;
    mid_r  <= mid_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
  end

  assign rd_addr_o   = mid_nxt;
  assign busy_o      = (state_r == SE_RUN);
  assign res_valid_o = res_valid_r;
  assign res_o       = res_r;

  // While searching, the range is never empty.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SE_RUN |-> len_r != '0)
    else $error("search range empty while running");

  // The probe lies inside the current range.
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SE_RUN |->
      (CW'(mid_r) >= base_r) && ((CW+1)'(mid_r) < (CW+1)'(base_r) + (CW+1)'(len_r)))
    else $error("probe outside search range");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.found |-> res_r.position == '0)
    else $error("miss with nonzero position");

  // No new search is started while one is running.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SE_RUN |-> !start_i)
    else $error("search started while busy");

endmodule

// File: hw/rtl/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top: sorted key table with binary search
// A word is accepted when start is high and busy is low. Clear and append
// words give no result. A search word on a non-empty table holds busy high
// while the engine probes it, with a single registered read of the key
// memory per halving step; the result strobe out_valid is high for one
// cycle right after the last probe, and a new word may be accepted in that
// same cycle. The receiver cannot stall, so every result must be taken the
// cycle it appears. No clearing pass is needed after reset: only entries
// below the entry count are ever read.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]        count_r, count_nxt;
  logic                 accept;
  logic                 wr_en;
  logic                 search_start;
  logic [KEY_WIDTH-1:0] key_ext;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;

  assign accept  = start && !busy;
  assign key_ext = KEY_WIDTH'(in_word.key_value);

  // Decode the accepted word: clear, append or search.
  always_comb begin
    count_nxt    = count_r;
    wr_en        = 1'b0;
    search_start = 1'b0;
    if (accept) begin
      unique case (in_word.op)
        OP_CLEAR: begin
          count_nxt = '0;
        end
        OP_APPEND: begin
          if (count_r < CW'(TABLE_DEPTH)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_SEARCH: begin
          search_start = 1'b1;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Key memory.
  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data (key_ext),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Search engine.
  stbs_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (search_start),
    .count_i     (count_r),
    .key_i       (key_ext),
    .rd_data_i   (rd_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .busy_o      (busy),
    .res_valid_o (out_valid),
    .res_o       (out_word)
  );

  // The entry count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // The table does not change while a search is running.
  a_stable_table: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(count_r))
    else $error("table changed during search");

  // A result follows only a search word or a running search.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(accept && (in_word.op == OP_SEARCH)))
    else $error("result without a search");

endmodule
